### hw/rtl/ltt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltt_pkg
// shared constants and command/status types of the transition table
// ----------------------------------------------------------------------------
package ltt_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);

  localparam logic [1:0] KindAdd   = 2'd0;
  localparam logic [1:0] KindTick  = 2'd1;
  localparam logic [1:0] KindQuery = 2'd2;
  localparam logic [1:0] KindClear = 2'd3;

  localparam logic [1:0] ResUpdate = 2'd0;
  localparam logic [1:0] ResAdd    = 2'd1;
  localparam logic [1:0] ResQuery  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic latch_req;   // capture request fields
    logic add;         // write entry at count
    logic clr;         // empty the table
    logic rd;          // read entry at index
    logic div_start;   // start divider on read entry
    logic emit_upd;    // emit value update
    logic emit_add;    // emit add status
    logic q_clr;       // clear query hit
    logic q_step;      // compare entry at index
    logic emit_q;      // emit query answer
    logic idx_clr;     // index to zero
  } ltt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;       // count is zero
    logic full;        // count at capacity
    logic idx_end;     // index reached count
  } ltt_sts_t;

endpackage

### hw/rtl/ltt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltt_div
// signed 49 by 16 bit restoring divider, one quotient bit per cycle,
// truncating toward zero
// ----------------------------------------------------------------------------
module ltt_div import ltt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [48:0] num_i,
  input  logic        [15:0] den_i,
  output logic               done_o,
  output logic signed [48:0] quo_o
);

  logic [48:0] rem_mag_q, rem_mag_d;   // shifting numerator magnitude / quotient
  logic [16:0] part_q, part_d;
  logic [15:0] den_q;
  logic        neg_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [16:0] trial;
  logic [17:0] diff;

  assign trial = {part_q[15:0], rem_mag_q[48]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};

  always_comb begin
    rem_mag_d = rem_mag_q;
    part_d    = part_q;
    cnt_d     = cnt_q;
    run_d     = run_q;
    done_d    = 1'b0;
    if (run_q) begin
      if (!diff[17]) begin
        part_d    = diff[16:0];
        rem_mag_d = {rem_mag_q[47:0], 1'b1};
      end else begin
        part_d    = trial;
        rem_mag_d = {rem_mag_q[47:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 6'd49;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_mag_q <= num_i[48] ? 49'(-num_i) : num_i;
      neg_q     <= num_i[48];
      den_q     <= den_i;
      part_q    <= '0;
    end else begin
      rem_mag_q <= rem_mag_d;
      part_q    <= part_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(rem_mag_q) : $signed(rem_mag_q);

endmodule

### hw/rtl/ltt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltt_datapath
// entry storage, request capture, interpolation arithmetic and result register
// ----------------------------------------------------------------------------
module ltt_datapath import ltt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ltt_cmd_t            cmd_i,
  output ltt_sts_t            sts_o,
  output logic                done_o,
  input  logic         [7:0]  tag_i,
  input  logic         [7:0]  target_id_i,
  input  logic signed  [31:0] start_value_i,
  input  logic signed  [31:0] end_value_i,
  input  logic         [15:0] duration_i,
  input  logic         [7:0]  query_tag_a_i,
  input  logic         [7:0]  query_tag_b_i,
  input  logic         [7:0]  query_tag_c_i,
  input  logic         [7:0]  query_tag_d_i,
  input  logic         [2:0]  query_count_i,
  output logic                valid_o,
  output logic         [1:0]  result_kind_o,
  output logic         [7:0]  out_target_o,
  output logic signed  [31:0] out_value_o,
  output logic                last_o,
  output logic                any_active_o,
  output logic                table_full_o
);

  typedef struct packed {
    logic [7:0]  tag;
    logic [7:0]  target;
    logic [31:0] start;
    logic [31:0] fin;
    logic [15:0] total;
    logic [15:0] elapsed;
  } entry_t;

  entry_t          mem_q [MaxEntries];
  entry_t          cur_q;
  entry_t          new_q;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] todo_q;
  logic [CntW-1:0] emitted_q;
  logic            hit_q;
  logic [7:0]      qt_q [4];
  logic [2:0]      qn_q;
  logic            valid_q;
  logic [1:0]      kind_q;
  logic [7:0]      tgt_q;
  logic [31:0]     val_q;
  logic            last_q, any_q, full_q;

  logic [15:0]        el_inc;
  logic               fin_now;
  logic signed [32:0] span;
  logic signed [48:0] prod;
  logic signed [48:0] quo;
  logic               div_done;
  logic [CntW-1:0]    last_idx;
  logic               tag_hit;
  logic [IdxW-1:0]    wr_idx;

  assign last_idx = cnt_q - CntW'(1);
  assign el_inc   = (cur_q.elapsed == 16'hFFFF) ? cur_q.elapsed : cur_q.elapsed + 16'd1;
  assign fin_now  = (cur_q.total == 16'd0) || (el_inc >= cur_q.total);
  assign span     = 33'(signed'(cur_q.fin)) - 33'(signed'(cur_q.start));
  assign prod     = 49'(span) * $signed({1'b0, el_inc});
  assign wr_idx   = idx_q[IdxW-1:0];

  ltt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start && !fin_now),
    .num_i   (prod),
    .den_i   (cur_q.total),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    tag_hit = 1'b0;
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < qn_q && mem_q[wr_idx].tag == qt_q[j]) tag_hit = 1'b1;
    end
  end

  // finished entries complete without the divider
  assign done_o = cmd_i.div_start ? fin_now : div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit_upd || cmd_i.emit_add || cmd_i.emit_q;
      if (cmd_i.clr) cnt_q <= '0;
      if (cmd_i.add) cnt_q <= cnt_q + CntW'(1);
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.q_step) begin
        idx_q <= idx_q + CntW'(1);
      end else if (cmd_i.emit_upd) begin
        if (fin_now) begin
          cnt_q <= last_idx;
        end else begin
          idx_q <= idx_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      qt_q[0]   <= query_tag_a_i;
      qt_q[1]   <= query_tag_b_i;
      qt_q[2]   <= query_tag_c_i;
      qt_q[3]   <= query_tag_d_i;
      qn_q      <= (query_count_i > 3'd4) ? 3'd4 : query_count_i;
      todo_q    <= cnt_q;
      emitted_q <= '0;
      new_q     <= '{tag: tag_i, target: target_id_i, start: start_value_i,
                     fin: end_value_i, total: duration_i, elapsed: 16'd0};
    end
    if (cmd_i.add) begin
      mem_q[cnt_q[IdxW-1:0]] <= new_q;
    end
    if (cmd_i.rd) cur_q <= mem_q[wr_idx];
    if (cmd_i.q_clr) hit_q <= 1'b0;
    if (cmd_i.q_step && tag_hit) hit_q <= 1'b1;
    if (cmd_i.emit_upd) begin
      emitted_q <= emitted_q + CntW'(1);
      if (fin_now) begin
        mem_q[wr_idx] <= mem_q[last_idx[IdxW-1:0]];
      end else begin
        mem_q[wr_idx].elapsed <= el_inc;
      end
    end
    if (cmd_i.emit_upd) begin
      kind_q <= ResUpdate;
      tgt_q  <= cur_q.target;
      val_q  <= fin_now ? cur_q.fin : 32'(signed'(cur_q.start) + quo[31:0]);
      last_q <= (emitted_q + CntW'(1)) == todo_q;
      any_q  <= 1'b0;
      full_q <= 1'b0;
    end else if (cmd_i.emit_add) begin
      kind_q <= ResAdd;
      tgt_q  <= '0;
      val_q  <= '0;
      last_q <= 1'b0;
      any_q  <= 1'b0;
      full_q <= sts_o.full;
    end else if (cmd_i.emit_q) begin
      kind_q <= ResQuery;
      tgt_q  <= '0;
      val_q  <= '0;
      last_q <= 1'b0;
      any_q  <= hit_q;
      full_q <= 1'b0;
    end else begin
      kind_q <= ResUpdate;
      tgt_q  <= '0;
      val_q  <= '0;
      last_q <= 1'b0;
      any_q  <= 1'b0;
      full_q <= 1'b0;
    end
  end

  assign sts_o.empty    = (cnt_q == '0);
  assign sts_o.full     = (cnt_q == CntW'(MaxEntries));
  assign sts_o.idx_end  = (idx_q >= cnt_q);

  assign valid_o       = valid_q;
  assign result_kind_o = kind_q;
  assign out_target_o  = tgt_q;
  assign out_value_o   = val_q;
  assign last_o        = last_q;
  assign any_active_o  = any_q;
  assign table_full_o  = full_q;

endmodule

### hw/rtl/ltt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltt_ctrl
// request sequencer: decodes the request kind and steps the datapath
// ----------------------------------------------------------------------------
module ltt_ctrl import ltt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] kind_i,
  output logic       busy,
  input  ltt_sts_t   sts_i,
  input  logic       done_i,
  output ltt_cmd_t   cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDec   = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StCalc  = 3'd3;
  localparam logic [2:0] StWait  = 3'd4;
  localparam logic [2:0] StQuery = 3'd5;

  logic [2:0] state_q, state_d;
  logic [1:0] kind_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.latch_req = 1'b1;
          cmd_o.idx_clr   = 1'b1;
          cmd_o.q_clr     = 1'b1;
          state_d         = StDec;
        end
      end
      StDec: begin
        state_d = StIdle;
        unique case (kind_q)
          KindAdd: begin
            cmd_o.emit_add = 1'b1;
            cmd_o.add      = !sts_i.full;
          end
          KindTick:  if (!sts_i.empty) state_d = StRead;
          KindQuery: state_d = StQuery;
          KindClear: cmd_o.clr = 1'b1;
          default: ;
        endcase
      end
      StRead: begin
        if (sts_i.idx_end) begin
          state_d = StIdle;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = StCalc;
        end
      end
      StCalc: begin
        cmd_o.div_start = 1'b1;
        if (done_i) begin
          cmd_o.emit_upd = 1'b1;
          state_d        = StRead;
        end else begin
          state_d = StWait;
        end
      end
      StWait: begin
        if (done_i) begin
          cmd_o.emit_upd = 1'b1;
          state_d        = StRead;
        end
      end
      StQuery: begin
        if (sts_i.idx_end) begin
          cmd_o.emit_q = 1'b1;
          state_d      = StIdle;
        end else begin
          cmd_o.q_step = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      kind_q  <= KindAdd;
    end else begin
      state_q <= state_d;
      if (state_q == StIdle && start) kind_q <= kind_i;
    end
  end

  assign busy = (state_q != StIdle);

endmodule

### hw/rtl/linear_transition_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_transition_table_top
// table of up to 16 linear transitions with add, tick, query and clear requests
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy low; results come one per
// strobe and cannot be stalled. A query compares the stored entries one by
// one. A tick walks the entries in turn: an entry that finishes completes
// without the divider, while an entry still running waits for the 49-step
// serial divider.
module linear_transition_table_top import ltt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic        [1:0]  kind_i,
  input  logic        [7:0]  tag_i,
  input  logic        [7:0]  target_id_i,
  input  logic signed [31:0] start_value_i,
  input  logic signed [31:0] end_value_i,
  input  logic        [15:0] duration_i,
  input  logic        [7:0]  query_tag_a_i,
  input  logic        [7:0]  query_tag_b_i,
  input  logic        [7:0]  query_tag_c_i,
  input  logic        [7:0]  query_tag_d_i,
  input  logic        [2:0]  query_count_i,
  output logic               valid_o,
  output logic        [1:0]  result_kind_o,
  output logic        [7:0]  out_target_o,
  output logic signed [31:0] out_value_o,
  output logic               last_o,
  output logic               any_active_o,
  output logic               table_full_o
);

  ltt_cmd_t cmd;
  ltt_sts_t sts;
  logic     done;

  ltt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .kind_i (kind_i),
    .busy   (busy),
    .sts_i  (sts),
    .done_i (done),
    .cmd_o  (cmd)
  );

  ltt_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .done_o        (done),
    .tag_i         (tag_i),
    .target_id_i   (target_id_i),
    .start_value_i (start_value_i),
    .end_value_i   (end_value_i),
    .duration_i    (duration_i),
    .query_tag_a_i (query_tag_a_i),
    .query_tag_b_i (query_tag_b_i),
    .query_tag_c_i (query_tag_c_i),
    .query_tag_d_i (query_tag_d_i),
    .query_count_i (query_count_i),
    .valid_o       (valid_o),
    .result_kind_o (result_kind_o),
    .out_target_o  (out_target_o),
    .out_value_o   (out_value_o),
    .last_o        (last_o),
    .any_active_o  (any_active_o),
    .table_full_o  (table_full_o)
  );

endmodule
